// ===== hdl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Operation codes carried on the input tuser.
  localparam logic [OpW-1:0] OP_INS_REAR = 3'd0;
  localparam logic [OpW-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OpW-1:0] OP_REM_REAR = 3'd2;
  localparam logic [OpW-1:0] OP_REM_FRONT = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR = 3'd4;
  localparam logic [OpW-1:0] OP_QUERY = 3'd5;

  // Status codes carried on the output tuser.
  localparam logic [StatusW-1:0] ST_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  // Movement broadcast to every cell of the row.
  typedef struct packed {
    logic shift_up;    // every cell takes the word of its lower neighbor
    logic shift_down;  // every cell takes the word of its upper neighbor
    logic load_en;     // the addressed cell takes the input word
  } cell_ctrl_t;

endpackage

// ===== hdl/deq_cell.sv =====
// One storage cell of the queue row.
`timescale 1ns / 1ps

module deq_cell
  import deq_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             load_sel_i,
  input  logic [DataW-1:0] lower_i,
  input  logic [DataW-1:0] upper_i,
  input  logic [DataW-1:0] value_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.shift_up) begin
      data_d = lower_i;
    end else if (ctrl_i.shift_down) begin
      data_d = upper_i;
    end else if (ctrl_i.load_en && load_sel_i) begin
      data_d = value_i;
    end else begin
      data_d = data_q;
    end
  end

  // Payload only; the valid range is kept by the count in the top level.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hdl/double_ended_queue.sv =====
// Top level of the double-ended queue built from a row of shifting cells.
`timescale 1ns / 1ps

// Usage:
// The slave-side stream carries one request per transfer: tuser holds the
// operation code and tdata the word to insert. The master-side stream
// returns exactly one response per request, in order: tuser holds the
// status and tdata the removed word, the rear and front words, the empty
// flag and the element count after the operation.
// Words live in a row of DEPTH cells. Cell 0 always holds the rear element
// and the elements run upward to the front, so an insert or remove at the
// rear shifts the whole row by one place, while the front end is written
// or dropped in place at the cell that the count names. A taken request is
// held in the pending register and then moves into the output register,
// from which its response is offered. A new request is taken once the
// previous one has moved into the output register; the single pending
// register, which frees only when its request moves on, keeps the block
// from taking a new request while another is still pending.
// A response waiting in the output register does not hold off the next
// request; if the receiver stalls, one further request is taken and kept
// until the output register frees. Reset empties the queue and drops any
// pending response; cell contents are not cleared.

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [DataW-1:0]     s_axis_tdata_i,   // value
  input  logic [OpW-1:0]       s_axis_tuser_i,   // op
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // removed_value, rear_value, front_value, is_empty, element_count, 2 pad bits
  output logic [103:0]         m_axis_tdata_o,
  output logic [StatusW-1:0]   m_axis_tuser_o    // status
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DataW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] load_sel;
  logic [DEPTH-1:0] front_hit;
  cell_ctrl_t       ctrl;

  logic [CntW-1:0]    count_d, count_q;
  logic               pend_q;
  logic [StatusW-1:0] pend_status_q, status_d;
  logic [DataW-1:0]   pend_removed_q, removed_d;
  logic [DataW-1:0]   front_word;
  logic               s_xfer, out_load, out_valid_q, full, empty;
  logic [CntW+4:0]    count_wide;

  logic [StatusW-1:0] out_status_q;
  logic [DataW-1:0]   out_removed_q, out_rear_q, out_front_q;
  logic               out_empty_q;
  logic [CountW-1:0]  out_count_q;

  assign s_axis_tready_o = !pend_q;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CntW'(DEPTH));
  assign empty           = (count_q == '0);

  // Front element sits in the cell just below the count.
  always_comb begin
    front_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      front_hit[i] = (count_q == CntW'(i + 1));
      load_sel[i]  = (count_q == CntW'(i));
      front_word   = front_word | (front_hit[i] ? cell_data[i] : '0);
    end
  end

  // Decode the request into row movement, the new count, the status and the removed word.
  always_comb begin
    ctrl      = '0;
    count_d   = count_q;
    status_d  = ST_OK;
    removed_d = '0;
    unique case (s_axis_tuser_i)
      OP_INS_REAR: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          count_d       = count_q + CntW'(1);
        end
      end
      OP_INS_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.load_en = 1'b1;
          count_d      = count_q + CntW'(1);
        end
      end
      OP_REM_REAR: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.shift_down = 1'b1;
          removed_d       = cell_data[0];
          count_d         = count_q - CntW'(1);
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = front_word;
          count_d   = count_q - CntW'(1);
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // Query and unused codes leave the queue untouched.
      end
    endcase
    if (!s_xfer) begin
      ctrl    = '0;
      count_d = count_q;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] lower, upper;
    if (g == 0) begin : g_bottom
      assign lower = s_axis_tdata_i;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    deq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_sel_i (load_sel[g]),
      .lower_i    (lower),
      .upper_i    (upper),
      .value_i    (s_axis_tdata_i),
      .data_o     (cell_data[g])
    );
  end

  assign out_load   = pend_q && (!out_valid_q || m_axis_tready_i);
  assign count_wide = (CntW + 5)'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_xfer) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request outcome, then the response built from the row.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      pend_status_q  <= status_d;
      pend_removed_q <= removed_d;
    end
    if (out_load) begin
      out_status_q  <= pend_status_q;
      out_removed_q <= pend_removed_q;
      out_rear_q    <= empty ? '0 : cell_data[0];
      out_front_q   <= empty ? '0 : front_word;
      out_empty_q   <= empty;
      out_count_q   <= count_wide[CountW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_count_q, out_empty_q, out_front_q, out_rear_q,
                            out_removed_q};

  // The count never passes the number of cells.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("element count above depth");

  // A rear insert that is not refused lands in cell 0 on the next cycle.
  a_rear_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == OP_INS_REAR) && !full
    |=> cell_data[0] == $past(s_axis_tdata_i))
    else $error("rear insert not in cell 0");

  // A taken request is held pending until it reaches the output register.
  a_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> pend_q || out_valid_q)
    else $error("request lost");

  // An empty response reports a zero count.
  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[96] |-> m_axis_tdata_o[101:97] == '0)
    else $error("empty flag disagrees with count");

endmodule

// ===== test/tb.sv =====
// Self-checking stream testbench for the double-ended queue.
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED = 40;

  // Codes the block treats like a query.
  localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   removed;
    logic [DataW-1:0]   rear;
    logic [DataW-1:0]   front;
    logic               empty;
    logic [CountW-1:0]  count;
  } deq_resp_t;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [DataW-1:0]   s_data = '0;
  logic [OpW-1:0]     s_user = OP_QUERY;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [103:0]       m_data;
  logic [StatusW-1:0] m_user;

  // Predictor state: a ring of words and the positions of both ends.
  logic [DataW-1:0]   slot_word [QDEPTH];
  int unsigned        rear_slot = 0;
  int unsigned        front_slot = 0;
  int unsigned        live_count = 0;

  deq_resp_t          pending_resp [$];
  int unsigned        mismatch_count = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        rx_hold = 0;
  bit                 tx_steady = 1'b0;
  bit                 rx_steady = 1'b0;

  double_ended_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Applies one operation to the predicted queue and returns the response it gives.
  function automatic deq_resp_t predict_response(logic [OpW-1:0] op, logic [DataW-1:0] word);
    deq_resp_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INS_REAR: begin
        if (live_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          // The first word lands where the rear already points.
          if (live_count == 0) front_slot = rear_slot;
          else rear_slot = (rear_slot == 0) ? QDEPTH - 1 : rear_slot - 1;
          slot_word[rear_slot] = word;
          live_count++;
        end
      end
      OP_INS_FRONT: begin
        if (live_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (live_count == 0) rear_slot = front_slot;
          else front_slot = (front_slot + 1 >= QDEPTH) ? 0 : front_slot + 1;
          slot_word[front_slot] = word;
          live_count++;
        end
      end
      OP_REM_REAR: begin
        if (live_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = slot_word[rear_slot];
          live_count--;
          // Removing the last word leaves both positions in place.
          if (live_count != 0) rear_slot = (rear_slot + 1 >= QDEPTH) ? 0 : rear_slot + 1;
        end
      end
      OP_REM_FRONT: begin
        if (live_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = slot_word[front_slot];
          live_count--;
          if (live_count != 0) front_slot = (front_slot == 0) ? QDEPTH - 1 : front_slot - 1;
        end
      end
      OP_CLEAR: begin
        live_count = 0;
        rear_slot = 0;
        front_slot = 0;
      end
      default: begin
      end
    endcase
    r.rear = (live_count != 0) ? slot_word[rear_slot] : '0;
    r.front = (live_count != 0) ? slot_word[front_slot] : '0;
    r.empty = (live_count == 0);
    r.count = live_count[CountW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_PRINTED) $display("tb: mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Sends one request and records the response it should produce once the transfer happens.
  task automatic issue_request(logic [OpW-1:0] op, logic [DataW-1:0] word);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= word;
    do @(posedge clk_i); while (!s_ready);
    pending_resp.push_back(predict_response(op, word));
  endtask

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OpW-1:0] pick_insert();
    return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR;
  endfunction

  function automatic logic [OpW-1:0] pick_remove();
    return $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_REAR;
  endfunction

  // The mix decides how often the queue grows or shrinks, at an end picked at random, so
  // the queue swings between empty and full rather than hovering at a few elements.
  function automatic logic [OpW-1:0] pick_op(mix_e mix);
    int unsigned r;
    int unsigned ins_cut;
    int unsigned rem_cut;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        ins_cut = 70;
        rem_cut = 88;
      end
      MIX_SHRINK: begin
        ins_cut = 20;
        rem_cut = 88;
      end
      default: begin
        ins_cut = 42;
        rem_cut = 84;
      end
    endcase
    if (r < ins_cut) return pick_insert();
    if (r < rem_cut) return pick_remove();
    if (r < 94) return OP_QUERY;
    if (r < 98) return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
    return OP_CLEAR;
  endfunction

  // Directed: both ends on an empty queue, the last element, clear, query and
  // the spare codes, with the extreme words.
  task automatic test_directed();
    issue_request(OP_QUERY, 32'h1234_5678);
    issue_request(OP_REM_REAR, 32'h0);
    issue_request(OP_REM_FRONT, 32'hffff_ffff);
    issue_request(OP_INS_REAR, 32'h7fff_ffff);
    issue_request(OP_REM_FRONT, 32'h0);
    issue_request(OP_INS_FRONT, 32'h8000_0000);
    issue_request(OP_INS_REAR, 32'hffff_ffff);
    issue_request(OP_INS_FRONT, 32'h0000_0000);
    issue_request(OP_INS_REAR, 32'h5555_5555);
    issue_request(OP_INS_FRONT, 32'haaaa_aaaa);
    issue_request(OP_SPARE_6, 32'hdead_beef);
    issue_request(OP_SPARE_7, 32'h0000_0001);
    issue_request(OP_REM_REAR, 32'h0);
    issue_request(OP_REM_FRONT, 32'h0);
    issue_request(OP_CLEAR, 32'hffff_ffff);
    issue_request(OP_QUERY, 32'h0);
    issue_request(OP_REM_REAR, 32'h0);
    issue_request(OP_INS_FRONT, 32'h0000_0001);
    issue_request(OP_REM_REAR, 32'h0);
    issue_request(OP_CLEAR, 32'h0);
  endtask

  // Fills to the brim from random ends, tries both ends once more, then empties
  // and removes once too often from each end.
  task automatic test_full_and_wrap();
    repeat (2) begin
      while (live_count < QDEPTH) issue_request(pick_insert(), pick_word());
      issue_request(OP_INS_REAR, pick_word());
      issue_request(OP_INS_FRONT, pick_word());
      while (live_count > 0) issue_request(pick_remove(), pick_word());
      issue_request(OP_REM_REAR, pick_word());
      issue_request(OP_REM_FRONT, pick_word());
    end
  endtask

  task automatic test_random_mix(int unsigned n_items);
    mix_e mix;
    int unsigned run_len;
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      mix = mix_e'($urandom_range(0, 2));
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        issue_request(pick_op(mix), pick_word());
        sent++;
      end
    end
  endtask

  // Full rate on both sides for a stretch.
  task automatic test_back_to_back();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (50) issue_request(pick_op(MIX_EVEN), pick_word());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // The sender holds off until every response is back, then carries on.
  task automatic test_pause_for_drain();
    repeat (12) issue_request(pick_op(MIX_GROW), pick_word());
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (18) issue_request(pick_op(MIX_SHRINK), pick_word());
  endtask

  // Response side: random stalls, none begun while a steady stretch runs.
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      m_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 7) == 0) rx_hold = pick_gap();
    end
  end

  // Every response transfer is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_resp
    deq_resp_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = pending_resp.pop_front();
        if (m_user !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_user, want.status));
        if (m_data[31:0] !== want.removed)
          report_mismatch($sformatf("removed %h, want %h", m_data[31:0], want.removed));
        if (m_data[63:32] !== want.rear)
          report_mismatch($sformatf("rear %h, want %h", m_data[63:32], want.rear));
        if (m_data[95:64] !== want.front)
          report_mismatch($sformatf("front %h, want %h", m_data[95:64], want.front));
        if (m_data[96] !== want.empty)
          report_mismatch($sformatf("empty %b, want %b", m_data[96], want.empty));
        if (m_data[101:97] !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", m_data[101:97], want.count));
      end
    end
  end

  // Watchdog: too long without a transfer on either side means a hang.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    test_directed();
    test_full_and_wrap();
    test_random_mix(380);
    test_back_to_back();
    test_pause_for_drain();
    s_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    // The extra wait catches any stray response.
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue.sv
test/tb.sv
